/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bcd_pkg.sv */
// ----------------------------------------------------------------------------
// Bounded circular deque package
// Command codes, field widths and fixed values shared by the deque files.
// ----------------------------------------------------------------------------
package bcd_pkg;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int CNT_W    = 7;
    localparam int CNT_MAX  = (2 ** CNT_W) - 1;

    localparam logic [CNT_W-1:0]         CAP_RESET  = CNT_W'(64);
    localparam logic signed [DATA_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_REAR  = 3'd1,
        CMD_DEL_FRONT = 3'd2,
        CMD_DEL_REAR  = 3'd3,
        CMD_QUERY     = 3'd4
    } cmd_t;

endpackage

/* sv/bcd_cmd_if.sv */
// ----------------------------------------------------------------------------
// Deque command channel
// Valid/ready channel carrying one command item and its data word.
// ----------------------------------------------------------------------------
interface bcd_cmd_if import bcd_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, output command, output item_value, input ready);
    modport sink   (input valid, input command, input item_value, output ready);

endinterface

/* sv/bcd_res_if.sv */
// ----------------------------------------------------------------------------
// Deque result channel
// Valid/ready channel carrying one result item per command.
// ----------------------------------------------------------------------------
interface bcd_res_if import bcd_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic                     done_ok;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
    logic [CNT_W-1:0]         item_count;

    modport source (
        output valid, output done_ok, output front_value, output rear_value,
        output is_empty, output is_full, output item_count, input ready
    );
    modport sink (
        input valid, input done_ok, input front_value, input rear_value,
        input is_empty, input is_full, input item_count, output ready
    );

endinterface

/* sv/bounded_circular_deque.sv */
// ----------------------------------------------------------------------------
// Bounded circular deque
// Double-ended queue of signed 32-bit words held in a ring RAM.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_chan takes one command item per handshake: insert front, insert rear,
//   delete front, delete rear or query, with the word to insert.
//   res_chan returns exactly one result item per command: success flag,
//   front and rear words (-1 when empty), empty and full flags, count.
//   cfg_we/cfg_wdata write the capacity (0 acts as 1, above DEPTH as DEPTH);
//   write it only while no result is outstanding.
//   The result is registered and valid in the cycle after the command is accepted.
//   Throughput: one command per cycle while results are taken; head, count and
//   the single RAM write all settle in that cycle, and the two RAM read ports fetch front and rear.
//   Reset empties the deque (head and count zero) and sets the capacity
//   to 64; the RAM is not cleared, since only held slots are ever read.
//   When the receiver stalls, the result holds and cmd_chan.ready stays low
//   until the result is taken; ready returns in the cycle it is taken.
// ----------------------------------------------------------------------------
module bounded_circular_deque import bcd_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    bcd_cmd_if.sink          cmd_chan,
    bcd_res_if.source        res_chan
);

    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW      = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam int CAP_MAX = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;

    logic [AW-1:0]            head_reg, head_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         cap_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     ok_reg, ok_next;
    logic                     full_reg, full_next;
    logic                     fwd_front_reg, fwd_front_next;
    logic                     fwd_rear_reg, fwd_rear_next;
    logic signed [DATA_W-1:0] wdata_reg;

    logic [CNT_W-1:0]         eff_cap;
    logic                     full_now;
    logic                     empty_now;
    logic                     accept;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            head_inc;
    logic [AW-1:0]            head_dec;
    logic [AW-1:0]            front_addr;
    logic [AW-1:0]            rear_addr;
    logic [DATA_W-1:0]        rd_front;
    logic [DATA_W-1:0]        rd_rear;

    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CNT_W-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(DEPTH))
        begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign cmd_chan.ready = !out_valid_reg || res_chan.ready;
    assign accept         = cmd_chan.valid && cmd_chan.ready;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(CAP_MAX))
        begin
            eff_cap = CNT_W'(CAP_MAX);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    assign full_now  = count_reg >= eff_cap;
    assign empty_now = count_reg == '0;
    assign head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec  = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);

    // Command decode
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        ok_next    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        unique case (cmd_t'(cmd_chan.command))
            CMD_INS_FRONT:
            begin
                if (!full_now)
                begin
                    head_next  = head_dec;
                    wr_addr    = head_dec;
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    ok_next    = 1'b1;
                end
            end
            CMD_INS_REAR:
            begin
                if (!full_now)
                begin
                    wr_addr    = wrap_add(head_reg, count_reg);
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    ok_next    = 1'b1;
                end
            end
            CMD_DEL_FRONT:
            begin
                if (!empty_now)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - CNT_W'(1);
                    ok_next    = 1'b1;
                end
            end
            CMD_DEL_REAR:
            begin
                if (!empty_now)
                begin
                    count_next = count_reg - CNT_W'(1);
                    ok_next    = 1'b1;
                end
            end
            CMD_QUERY:
            begin
                ok_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    assign full_next      = count_next >= eff_cap;
    assign front_addr     = head_next;
    assign rear_addr      = wrap_add(head_next, count_next - CNT_W'(1));
    assign fwd_front_next = wr_en && (front_addr == wr_addr);
    assign fwd_rear_next  = wr_en && (rear_addr == wr_addr);

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    bcd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .we      (accept && wr_en),
        .waddr   (wr_addr),
        .wdata   (cmd_chan.item_value),
        .re      (accept),
        .raddr_a (front_addr),
        .raddr_b (rear_addr),
        .rdata_a (rd_front),
        .rdata_b (rd_rear)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            full_reg      <= 1'b0;
            fwd_front_reg <= 1'b0;
            fwd_rear_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (accept)
            begin
                head_reg      <= head_next;
                count_reg     <= count_next;
                ok_reg        <= ok_next;
                full_reg      <= full_next;
                fwd_front_reg <= fwd_front_next;
                fwd_rear_reg  <= fwd_rear_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wdata_reg <= cmd_chan.item_value;
        end
    end

    assign res_chan.valid       = out_valid_reg;
    assign res_chan.done_ok     = ok_reg;
    assign res_chan.is_empty    = count_reg == '0;
    assign res_chan.is_full     = full_reg;
    assign res_chan.item_count  = count_reg;
    assign res_chan.front_value = (count_reg == '0) ? EMPTY_WORD :
                                  fwd_front_reg ? wdata_reg : $signed(rd_front);
    assign res_chan.rear_value  = (count_reg == '0) ? EMPTY_WORD :
                                  fwd_rear_reg ? wdata_reg : $signed(rd_rear);

endmodule

/* sv/bcd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered under a read enable.
// ----------------------------------------------------------------------------
module bcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                       rdata_a,
    output logic [WIDTH-1:0]                       rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* sv/bcd_checker.sv */
// ----------------------------------------------------------------------------
// Bounded circular deque checker
// Port-level assertions on the deque, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcd_checker import bcd_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     cmd_valid,
    input logic                     cmd_ready,
    input logic [CMD_W-1:0]         command,
    input logic                     res_valid,
    input logic                     res_ready,
    input logic                     done_ok,
    input logic signed [DATA_W-1:0] front_value,
    input logic signed [DATA_W-1:0] rear_value,
    input logic                     is_empty,
    input logic                     is_full,
    input logic [CNT_W-1:0]         item_count
);

    logic                        cmd_fire;
    logic                        query_fire;
    logic                        res_stall;
    logic                        words_empty;
    logic [2*DATA_W+CNT_W+2:0]   res_word;

    assign cmd_fire    = cmd_valid && cmd_ready;
    assign query_fire  = cmd_fire && (command == CMD_QUERY);
    assign res_stall   = res_valid && !res_ready;
    assign words_empty = (front_value == EMPTY_WORD) && (rear_value == EMPTY_WORD) &&
                         (item_count == '0);
    assign res_word    = {done_ok, front_value, rear_value, is_empty, is_full, item_count};

    `ASSERT_NEXT(a_one_cycle, cmd_fire, res_valid, "result missing after item")
    `ASSERT_IMPLY(a_empty_words, res_valid && is_empty, words_empty, "empty result shows data")
    `ASSERT_NEXT(a_query_ok, query_fire, done_ok && $stable(item_count), "query refused or count moved")
    `ASSERT_IMPLY(a_full_not_empty, res_valid && is_full, !is_empty, "full and empty together")
    `ASSERT_NEXT(a_stall_hold, res_stall, res_valid && $stable(res_word), "stalled result changed")

endmodule

bind bounded_circular_deque bcd_checker u_bcd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_chan.valid),
    .cmd_ready   (cmd_chan.ready),
    .command     (cmd_chan.command),
    .res_valid   (res_chan.valid),
    .res_ready   (res_chan.ready),
    .done_ok     (res_chan.done_ok),
    .front_value (res_chan.front_value),
    .rear_value  (res_chan.rear_value),
    .is_empty    (res_chan.is_empty),
    .is_full     (res_chan.is_full),
    .item_count  (res_chan.item_count)
);

/* tb/tb_bounded_circular_deque.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded circular deque testbench
// Drives deque commands through the valid/ready command channel and checks
// every result item against an in-bench model of the ring, head and count.
// A short directed table covers the empty and full edges, refused and unused
// commands and odd capacity values; random phases under several capacities
// follow, with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb_bounded_circular_deque import bcd_pkg::*; ();

    localparam int DEPTH        = 64;
    localparam int AW           = $clog2(DEPTH);
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AFTER   = 700;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 1000;

    localparam logic [CMD_W-1:0]         CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0]         CMD_UNUSED_MID = 3'd6;
    localparam logic [CMD_W-1:0]         CMD_UNUSED_HI = 3'd7;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] rear;
        logic                     empty;
        logic                     full;
        logic [CNT_W-1:0]         count;
    } deque_view_t;

    typedef struct packed {
        bit                       cap_write;
        logic [CNT_W-1:0]         cap_value;
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
        bit                       pinned;
        deque_view_t              view;
    } step_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    bcd_cmd_if cmd_if ();
    bcd_res_if res_if ();

    bounded_circular_deque #(.DEPTH(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_chan  (cmd_if),
        .res_chan  (res_if)
    );

    // deque model
    logic signed [DATA_W-1:0] ring_words [DEPTH];
    logic [AW-1:0]            head_slot = '0;
    logic [CNT_W-1:0]         held = '0;
    logic [CNT_W-1:0]         cap_model = CAP_RESET;

    step_row_t   row_q [$];
    deque_view_t view_q [$];
    int          mismatches = 0;
    int          commands_done = 0;
    int          refused = 0;
    int          full_seen = 0;
    int          cap_writes = 0;
    int          results_seen = 0;
    bit          no_idle = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic step_row_t cmd_row(logic [CMD_W-1:0] c, logic signed [DATA_W-1:0] v);
        step_row_t r;
        r = '0;
        r.command = c;
        r.value = v;
        return r;
    endfunction

    function automatic step_row_t pinned_row(logic [CMD_W-1:0] c, logic signed [DATA_W-1:0] v,
                                             logic ok, logic signed [DATA_W-1:0] fr,
                                             logic signed [DATA_W-1:0] rr, logic em, logic fu,
                                             logic [CNT_W-1:0] n);
        step_row_t r;
        r = cmd_row(c, v);
        r.pinned = 1'b1;
        r.view = '{ok: ok, front: fr, rear: rr, empty: em, full: fu, count: n};
        return r;
    endfunction

    function automatic step_row_t cap_row(logic [CNT_W-1:0] v);
        step_row_t r;
        r = '0;
        r.cap_write = 1'b1;
        r.cap_value = v;
        return r;
    endfunction

    // predict on command accept, check on result accept
    always @(posedge clk)
    begin : scoreboard
        deque_view_t want;
        deque_view_t got;
        step_row_t   row;
        logic [CNT_W-1:0] cap_eff;

        if (cfg_we)
        begin
            cap_model = cfg_wdata;
            cap_writes++;
        end

        if (cmd_if.valid && cmd_if.ready)
        begin
            cap_eff = (cap_model == 0) ? CNT_W'(1) :
                      (cap_model > DEPTH) ? CNT_W'(DEPTH) : cap_model;
            want = '0;
            case (cmd_t'(cmd_if.command))
                CMD_INS_FRONT:
                    if (held < cap_eff)
                    begin
                        head_slot = head_slot - AW'(1);
                        ring_words[head_slot] = cmd_if.item_value;
                        held++;
                        want.ok = 1'b1;
                    end
                CMD_INS_REAR:
                    if (held < cap_eff)
                    begin
                        ring_words[AW'(head_slot + held)] = cmd_if.item_value;
                        held++;
                        want.ok = 1'b1;
                    end
                CMD_DEL_FRONT:
                    if (held != 0)
                    begin
                        head_slot = head_slot + AW'(1);
                        held--;
                        want.ok = 1'b1;
                    end
                CMD_DEL_REAR:
                    if (held != 0)
                    begin
                        held--;
                        want.ok = 1'b1;
                    end
                CMD_QUERY:
                    want.ok = 1'b1;
                default:
                    want.ok = 1'b0;
            endcase
            want.count = held;
            want.empty = (held == 0);
            want.full  = (held >= cap_eff);
            want.front = want.empty ? EMPTY_WORD : ring_words[head_slot];
            want.rear  = want.empty ? EMPTY_WORD : ring_words[AW'(head_slot + held - 7'd1)];
            if (!want.ok)
                refused++;
            if (want.full)
                full_seen++;
            row = row_q.pop_front();
            if (row.pinned)
                want = row.view;
            view_q = {view_q, want};
            commands_done++;
        end

        if (res_if.valid && res_if.ready)
        begin
            results_seen <= results_seen + 1;
            got = '{ok: res_if.done_ok, front: res_if.front_value, rear: res_if.rear_value,
                    empty: res_if.is_empty, full: res_if.is_full, count: res_if.item_count};
            if (view_q.size() == 0)
            begin
                $error("result item with no command outstanding");
                mismatches++;
            end
            else
            begin
                want = view_q.pop_front();
                if (got.ok !== want.ok)
                begin
                    $error("done_ok: expected %0d, got %0d", want.ok, got.ok);
                    mismatches++;
                end
                if (got.front !== want.front)
                begin
                    $error("front_value: expected %0d, got %0d", want.front, got.front);
                    mismatches++;
                end
                if (got.rear !== want.rear)
                begin
                    $error("rear_value: expected %0d, got %0d", want.rear, got.rear);
                    mismatches++;
                end
                if (got.empty !== want.empty)
                begin
                    $error("is_empty: expected %0d, got %0d", want.empty, got.empty);
                    mismatches++;
                end
                if (got.full !== want.full)
                begin
                    $error("is_full: expected %0d, got %0d", want.full, got.full);
                    mismatches++;
                end
                if (got.count !== want.count)
                begin
                    $error("item_count: expected %0d, got %0d", want.count, got.count);
                    mismatches++;
                end
            end
        end
    end

    // result side: random idling plus one long hold
    initial
    begin : result_sink
        int  hold_left;
        bit  held_off;
        hold_left = 0;
        held_off = 1'b0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_off && results_seen >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else
                res_if.ready <= rst_n && (no_idle || $urandom_range(0, 99) >= 6);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_item(step_row_t row);
        row_q = {row_q, row};
        while (!no_idle && $urandom_range(0, 99) < 6)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.command    <= row.command;
        cmd_if.item_value <= row.value;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (view_q.size() != 0);
    endtask

    task automatic set_capacity(logic [CNT_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        step_row_t        plan [$];
        logic [CNT_W-1:0] phase_cap [PHASES];
        logic [CMD_W-1:0] c;
        logic signed [DATA_W-1:0] v;
        bit               filling;
        int               mode_left;
        int               r;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= CAP_RESET;
        cmd_if.valid      <= 1'b0;
        cmd_if.command    <= CMD_QUERY;
        cmd_if.item_value <= '0;

        plan = '{
            pinned_row(CMD_QUERY, 0, 1, EMPTY_WORD, EMPTY_WORD, 1, 0, 0),
            pinned_row(CMD_DEL_FRONT, 0, 0, EMPTY_WORD, EMPTY_WORD, 1, 0, 0),
            pinned_row(CMD_DEL_REAR, 0, 0, EMPTY_WORD, EMPTY_WORD, 1, 0, 0),
            pinned_row(CMD_INS_REAR, WORD_MAX, 1, WORD_MAX, WORD_MAX, 0, 0, 1),
            pinned_row(CMD_INS_FRONT, WORD_MIN, 1, WORD_MIN, WORD_MAX, 0, 0, 2),
            pinned_row(CMD_UNUSED_HI, 0, 0, WORD_MIN, WORD_MAX, 0, 0, 2),
            pinned_row(CMD_UNUSED_LO, WORD_MAX, 0, WORD_MIN, WORD_MAX, 0, 0, 2),
            cap_row(7'd2),
            pinned_row(CMD_QUERY, 0, 1, WORD_MIN, WORD_MAX, 0, 1, 2),
            pinned_row(CMD_INS_REAR, 5, 0, WORD_MIN, WORD_MAX, 0, 1, 2),
            cap_row(7'd0),
            pinned_row(CMD_INS_FRONT, 9, 0, WORD_MIN, WORD_MAX, 0, 1, 2),
            pinned_row(CMD_DEL_FRONT, 0, 1, WORD_MAX, WORD_MAX, 0, 1, 1),
            pinned_row(CMD_DEL_REAR, 0, 1, EMPTY_WORD, EMPTY_WORD, 1, 0, 0),
            pinned_row(CMD_INS_FRONT, -1, 1, -1, -1, 0, 1, 1),
            pinned_row(CMD_INS_REAR, 3, 0, -1, -1, 0, 1, 1),
            cap_row(7'd127),
            cmd_row(CMD_INS_REAR, 0),
            cmd_row(CMD_INS_REAR, 32'sh5555_5555),
            cmd_row(CMD_INS_FRONT, 32'shAAAA_AAAA),
            cmd_row(CMD_UNUSED_MID, -1),
            cmd_row(CMD_DEL_REAR, 0),
            cmd_row(CMD_DEL_FRONT, 0),
            cmd_row(CMD_DEL_FRONT, 0),
            cmd_row(CMD_DEL_FRONT, 0),
            cmd_row(CMD_DEL_REAR, 0),
            cap_row(CAP_RESET)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].cap_write)
                set_capacity(plan[i].cap_value);
            else
                send_item(plan[i]);
        end

        phase_cap = '{7'd127, 7'd1, 7'($urandom_range(2, 8)), CAP_RESET,
                      7'($urandom_range(0, 127)), 7'd0};
        filling = 1'b1;
        mode_left = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            set_capacity(phase_cap[p]);
            no_idle <= (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (mode_left == 0)
                begin
                    filling = ~filling;
                    mode_left = $urandom_range(20, 100);
                end
                mode_left--;
                r = $urandom_range(0, 99);
                if (r < 2)
                    c = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
                else if (r < 5)
                    c = CMD_QUERY;
                else if (r < 45)
                    c = filling ? CMD_INS_FRONT : CMD_DEL_FRONT;
                else if (r < 85)
                    c = filling ? CMD_INS_REAR : CMD_DEL_REAR;
                else if (r < 93)
                    c = filling ? CMD_DEL_FRONT : CMD_INS_FRONT;
                else
                    c = filling ? CMD_DEL_REAR : CMD_INS_REAR;
                case ($urandom_range(0, 7))
                    0: v = WORD_MAX;
                    1: v = WORD_MIN;
                    2: v = -1;
                    3: v = 0;
                    default: v = $urandom();
                endcase
                send_item(cmd_row(c, v));
            end
        end
        no_idle <= 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d deque commands under %0d capacity writes (%0d refused).",
                 commands_done, cap_writes, refused);
        $display("The deque reported full after %0d of those commands.", full_seen);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
